// ===== sv/aps_pkg.sv =====
// Shared types and constants for the aging priority scheduler.
`timescale 1ns / 1ps
`default_nettype none
package aps_pkg;

  localparam int SLOT_W = 6;
  localparam int PRIO_W = 5;
  localparam int CNT_W  = 16;

  localparam logic [PRIO_W-1:0] PRIO_BEST  = 5'd0;
  localparam logic [PRIO_W-1:0] PRIO_WORST = 5'd31;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;

  localparam logic KIND_PASS = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // Contents of one slot as it travels along the ring.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  count;
    logic              run;
  } slot_t;

  // Ring control from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic load_mask;
  } ring_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/aps_cell.sv =====
// One scheduler cell: holds one slot and passes it to its neighbor on a shift.
`timescale 1ns / 1ps
`default_nettype none
module aps_cell
  import aps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ring_ctrl_t        ring,
  input  wire logic              mask_bit,
  input  wire logic              wr_en,
  input  wire logic [PRIO_W-1:0] wr_prio,
  input  wire slot_t             nb_in,
  output slot_t                  q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ring.shift) begin
      q <= nb_in;
    end else if (ring.load_mask) begin
      q.run <= mask_bit;
    end else if (wr_en) begin
      q.prio <= wr_prio;
    end
  end

endmodule
`default_nettype wire

// ===== sv/aps_ctrl.sv =====
// Pass sequencer: minimum sweep, update sweep and the result register.
`timescale 1ns / 1ps
`default_nettype none
module aps_ctrl
  import aps_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              kind,
  input  wire slot_t             head,
  output slot_t                  wb,
  output ring_ctrl_t             ring,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   grant_valid,
  output logic [SLOT_W-1:0]      granted_slot,
  output logic [CNT_W-1:0]       run_count,
  output logic                   last
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam logic [IW-1:0] K_LAST = IW'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_MIN, ST_UPD, ST_ACK} state_t;

  state_t            state;
  logic [IW-1:0]     k;
  logic [PRIO_W-1:0] best;
  logic              any;
  logic [IW-1:0]     last_idx;

  logic out_can;
  logic grant;
  logic any_next;
  logic out_load;

  assign in_ready = (state == ST_IDLE);
  assign out_can  = !out_valid || out_ready;
  assign grant    = head.run && (head.prio == best);
  assign any_next = any || head.run;
  assign out_load = ((state == ST_UPD) && ring.shift && grant) ||
                    ((state == ST_ACK) && out_can);

  always_comb begin
    wb             = head;
    ring.shift     = 1'b0;
    ring.load_mask = (state == ST_IDLE) && in_valid && (kind == KIND_PASS);
    unique case (state)
      ST_MIN: ring.shift = 1'b1;
      ST_UPD: begin
        if (grant) begin
          if (head.count != CNT_MAX) wb.count = head.count + 1'b1;
          if (head.prio != PRIO_WORST) wb.prio = head.prio + 1'b1;
          ring.shift = out_can;
        end else begin
          if (head.run && head.prio != PRIO_BEST) wb.prio = head.prio - 1'b1;
          ring.shift = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      best      <= PRIO_WORST;
      any       <= 1'b0;
      last_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            k        <= '0;
            best     <= PRIO_WORST;
            any      <= 1'b0;
            last_idx <= '0;
            state    <= (kind == KIND_SET) ? ST_ACK : ST_MIN;
          end
        end
        ST_MIN: begin
          any <= any_next;
          if (head.run) begin
            if (head.prio <= best) last_idx <= k;
            if (head.prio < best) best <= head.prio;
          end
          if (k == K_LAST) begin
            k     <= '0;
            state <= any_next ? ST_UPD : ST_ACK;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_UPD: begin
          if (ring.shift) begin
            if (grant) begin
              grant_valid  <= 1'b1;
              granted_slot <= SLOT_W'(k);
              run_count    <= wb.count;
              last         <= (k == last_idx);
            end
            if (k == K_LAST) begin
              k     <= '0;
              state <= ST_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        ST_ACK: begin
          if (out_can) begin
            grant_valid  <= 1'b0;
            granted_slot <= '0;
            run_count    <= '0;
            last         <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A grant blocked by a full result register freezes the sweep.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && grant && !out_can) |=> ($stable(k) && state == ST_UPD))
    else $error("update sweep moved while a grant was blocked");

  // The ring only moves during the two sweeps.
  a_shift_in_sweep: assert property (@(posedge clk) disable iff (rst)
    ring.shift |-> (state == ST_MIN || state == ST_UPD))
    else $error("ring shifted outside a sweep");

  // The update sweep only runs when some slot was runnable.
  a_upd_has_any: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> any)
    else $error("update sweep with nothing runnable");

  // The final grant of a pass carries last.
  a_last_grant: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && ring.shift && grant && k == last_idx) |=>
      (out_valid && grant_valid && last))
    else $error("final grant lost its last flag");

endmodule
`default_nettype wire

// ===== sv/aging_priority_scheduler.sv =====
// Top level of the aging priority scheduler: a ring of slot cells and a sequencer.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_ready     kind, runnable_mask, target_slot, new_priority
//   output    out        out_valid / out_ready   grant_valid, granted_slot, run_count, last
//
// A set item writes its slot on acceptance; the sequencer then enters its
// acknowledge state, which loads the acknowledgment into the result register.
// A pass rotates the ring of cells once to find the least priority, then once
// more to update each slot and emit grants; the slot at the head of the ring is
// the only one examined in a cycle, and a grant blocked at the output holds the
// ring. A pass with nothing runnable skips the update sweep and loads an empty
// result instead. An acknowledgment or empty result waits while the result
// register is full.
// Reset (rst, synchronous) clears every priority, run count and runnable bit.
// Input is taken only while the sequencer is idle; a result left waiting in the
// output register does not block acceptance, but a grant it blocks holds the ring.
`timescale 1ns / 1ps
`default_nettype none
module aging_priority_scheduler
  import aps_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [63:0]        runnable_mask,
  input  wire logic [SLOT_W-1:0]  target_slot,
  input  wire logic signed [15:0] new_priority,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    grant_valid,
  output logic [SLOT_W-1:0]       granted_slot,
  output logic [CNT_W-1:0]        run_count,
  output logic                    last
);

  slot_t      cell_q [NUM_SLOTS];
  slot_t      wb;
  ring_ctrl_t ring;
  logic [PRIO_W-1:0] clamped;
  logic              set_wr;

  // Negative requests become the best priority, large ones the worst.
  always_comb begin
    if (new_priority[15]) begin
      clamped = PRIO_BEST;
    end else if (|new_priority[14:PRIO_W]) begin
      clamped = PRIO_WORST;
    end else begin
      clamped = new_priority[PRIO_W-1:0];
    end
  end

  assign set_wr = in_valid && in_ready && (kind == KIND_SET);

  // Cell 0 is the head of the ring; the sequencer writes the processed slot
  // back into the far end, so after one full rotation every slot is home again.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    slot_t nb;
    logic  wr_en;
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign nb = wb;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    // Slots past the table never match, so such writes are dropped.
    assign wr_en = set_wr && (target_slot == SLOT_W'(i));

    aps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ring     (ring),
      .mask_bit (runnable_mask[i]),
      .wr_en    (wr_en),
      .wr_prio  (clamped),
      .nb_in    (nb),
      .q        (cell_q[i])
    );
  end

  aps_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .head         (cell_q[0]),
    .wb           (wb),
    .ring         (ring),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .grant_valid  (grant_valid),
    .granted_slot (granted_slot),
    .run_count    (run_count),
    .last         (last)
  );

endmodule
`default_nettype wire
